FILE: hw/rtl/tcpq_pkg.sv
// ============================================================================
// tcpq_pkg: shared types and constants of the two-class priority queue
// Field widths, command and status codes, the stored entry layout and the
// string cut that clears every byte after the first zero byte.
// ============================================================================
`default_nettype none

package tcpq_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int WORD_W   = 64;
   localparam int TAIL_W   = 56;
   localparam int ID_BITS   = WORD_W + TAIL_W;             // 15 characters
   localparam int NAME_BITS = 3 * WORD_W + TAIL_W;         // 31 characters
   localparam int NAME_BYTES = NAME_BITS / 8;

   localparam logic [CMD_W-1:0] CMD_APPEND_REGULAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND_EMERGENCY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SERVE            = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED           = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_QUEUED      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SERVED_URG  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SERVED_REG  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_IDLE        = 3'd4;

   typedef struct packed {
      logic [TAIL_W-1:0] label_w3;
      logic [WORD_W-1:0] label_w2;
      logic [WORD_W-1:0] label_w1;
      logic [WORD_W-1:0] label_w0;
      logic [TAIL_W-1:0] id_high;
      logic [WORD_W-1:0] id_low;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control from the top level to one queue.
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   // Occupancy flags from one queue to the top level.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_sts_type;

   // Clears every byte that follows the first zero byte of a string.
   function automatic logic [NAME_BITS-1:0] cut_text(input logic [NAME_BITS-1:0] s);
      logic                 ended;
      logic [NAME_BITS-1:0] r;
      ended = 1'b0;
      r     = s;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (ended) begin
            r[8*b +: 8] = 8'h00;
         end else if (s[8*b +: 8] == 8'h00) begin
            ended = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcpq_req_if.sv
// ============================================================================
// tcpq_req_if: request channel of the two-class priority queue
// Valid/ready handshake carrying a command and one entry's characters.
// ============================================================================
`default_nettype none

interface tcpq_req_if
   import tcpq_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [WORD_W-1:0] id_low;
   logic [TAIL_W-1:0] id_high;
   logic [WORD_W-1:0] label_w0;
   logic [WORD_W-1:0] label_w1;
   logic [WORD_W-1:0] label_w2;
   logic [TAIL_W-1:0] label_w3;

   modport source (
      output valid, cmd, id_low, id_high, label_w0, label_w1, label_w2, label_w3,
      input  ready
   );

   modport sink (
      input  valid, cmd, id_low, id_high, label_w0, label_w1, label_w2, label_w3,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/tcpq_rsp_if.sv
// ============================================================================
// tcpq_rsp_if: response channel of the two-class priority queue
// Valid/ready handshake carrying a status and the served entry's characters.
// ============================================================================
`default_nettype none

interface tcpq_rsp_if
   import tcpq_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   out_id_low;
   logic [TAIL_W-1:0]   out_id_high;
   logic [WORD_W-1:0]   out_label_w0;
   logic [WORD_W-1:0]   out_label_w1;
   logic [WORD_W-1:0]   out_label_w2;
   logic [TAIL_W-1:0]   out_label_w3;

   modport source (
      output valid, status, out_id_low, out_id_high,
             out_label_w0, out_label_w1, out_label_w2, out_label_w3,
      input  ready
   );

   modport sink (
      input  valid, status, out_id_low, out_id_high,
             out_label_w0, out_label_w1, out_label_w2, out_label_w3,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/tcpq_ram.sv
// ============================================================================
// tcpq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds while
// no read is requested.
// ============================================================================
`default_nettype none

module tcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tcpq_queue.sv
// ============================================================================
// tcpq_queue: one circular FIFO of entries
// Head, tail and count registers around a RAM; a pop presents the head entry
// on the registered read port in the following cycle.
// ============================================================================
`default_nettype none

module tcpq_queue
   import tcpq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_ctl_type ctl,
   input  wire entry_type     wr_entry,
   output queue_sts_type      sts,
   output entry_type          rd_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ENTRY_W-1:0] rd_bits;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (ctl.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      unique case ({ctl.push, ctl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign sts.full  = (count_ff == FULL_CNT);
   assign sts.empty = (count_ff == '0);

   tcpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (ctl.pop),
      .rd_addr (head_ff),
      .rd_data (rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

endmodule

`default_nettype wire

FILE: hw/rtl/two_class_priority_queue.sv
// ============================================================================
// two_class_priority_queue: strict-priority emergency/regular entry queue
// Two FIFOs of identifier/name entries; service drains emergency first.
// ============================================================================
`default_nettype none

// Each request word carries a command and one entry: a 15-character identifier
// and a 31-character name, packed with the first character in the low byte.
// An append stores the entry, with every byte after its first zero byte
// cleared, at the tail of the emergency or regular queue and answers queued,
// or dropped when that queue already holds its depth of entries. A serve pops
// the emergency head if there is one, else the regular head, and returns it;
// with both queues empty, and for the unused command, the answer is idle with
// all character fields zero. Every request word yields exactly one response
// word, in order. The block takes one request word per cycle as long as the
// response side keeps up, and each response appears in the cycle after its
// request was taken: the decision is made from the queue counts at the
// request edge, and the served entry comes out of the queue RAM's registered
// read port in the following cycle. While a response word waits, the request
// side is held off. Each queue is a RAM of its depth parameter times 368
// bits; the RAM contents need no clearing after reset.

module two_class_priority_queue
   import tcpq_pkg::*;
#(
   parameter int URGENT_DEPTH = 16,
   parameter int NORMAL_DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tcpq_req_if.sink  req,
   tcpq_rsp_if.source rsp
);

   logic                req_fire;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   queue_ctl_type urgent_ctl, normal_ctl;
   queue_sts_type urgent_sts, normal_sts;
   entry_type     new_entry, urgent_rd, normal_rd, out_entry;

   logic [NAME_BITS-1:0] id_cut, name_cut;

   // A new word may enter whenever the response register is free or is
   // being emptied in this same cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   // Strings end at the first zero byte; everything after it is stored as zero.
   assign id_cut   = cut_text(NAME_BITS'({req.id_high, req.id_low}));
   assign name_cut = cut_text({req.label_w3, req.label_w2, req.label_w1, req.label_w0});

   always_comb begin
      new_entry          = '0;
      new_entry.id_low   = id_cut[WORD_W-1:0];
      new_entry.id_high  = id_cut[ID_BITS-1:WORD_W];
      new_entry.label_w0 = name_cut[WORD_W-1:0];
      new_entry.label_w1 = name_cut[2*WORD_W-1:WORD_W];
      new_entry.label_w2 = name_cut[3*WORD_W-1:2*WORD_W];
      new_entry.label_w3 = name_cut[NAME_BITS-1:3*WORD_W];
   end

   // Decide the outcome of the word from the queue flags as they stand now,
   // and steer the push or pop to the right queue.
   always_comb begin
      urgent_ctl = '0;
      normal_ctl = '0;
      status_in  = STATUS_IDLE;
      unique case (req.cmd)
         CMD_APPEND_REGULAR: begin
            status_in       = normal_sts.full ? STATUS_DROPPED : STATUS_QUEUED;
            normal_ctl.push = req_fire && !normal_sts.full;
         end
         CMD_APPEND_EMERGENCY: begin
            status_in       = urgent_sts.full ? STATUS_DROPPED : STATUS_QUEUED;
            urgent_ctl.push = req_fire && !urgent_sts.full;
         end
         CMD_SERVE: begin
            priority if (!urgent_sts.empty) begin
               status_in      = STATUS_SERVED_URG;
               urgent_ctl.pop = req_fire;
            end else if (!normal_sts.empty) begin
               status_in      = STATUS_SERVED_REG;
               normal_ctl.pop = req_fire;
            end else begin
               status_in = STATUS_IDLE;
            end
         end
         CMD_UNUSED: begin
            status_in = STATUS_IDLE;
         end
         default: begin
            status_in = STATUS_IDLE;
         end
      endcase
   end

   tcpq_queue #(
      .DEPTH (URGENT_DEPTH)
   ) u_urgent (
      .clock    (clock),
      .reset    (reset),
      .ctl      (urgent_ctl),
      .wr_entry (new_entry),
      .sts      (urgent_sts),
      .rd_entry (urgent_rd)
   );

   tcpq_queue #(
      .DEPTH (NORMAL_DEPTH)
   ) u_normal (
      .clock    (clock),
      .reset    (reset),
      .ctl      (normal_ctl),
      .wr_entry (new_entry),
      .sts      (normal_sts),
      .rd_entry (normal_rd)
   );

   // Response register. The RAM read registers only change on a pop, so the
   // served entry stays put while the response waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
      end
   end

   always_comb begin
      unique case (status_ff)
         STATUS_SERVED_URG: out_entry = urgent_rd;
         STATUS_SERVED_REG: out_entry = normal_rd;
         default:           out_entry = '0;
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.out_id_low   = out_entry.id_low;
   assign rsp.out_id_high  = out_entry.id_high;
   assign rsp.out_label_w0 = out_entry.label_w0;
   assign rsp.out_label_w1 = out_entry.label_w1;
   assign rsp.out_label_w2 = out_entry.label_w2;
   assign rsp.out_label_w3 = out_entry.label_w3;

endmodule

`default_nettype wire

FILE: hw/rtl/tcpq_checker.sv
// ============================================================================
// tcpq_checker: port-level checks of the two-class priority queue
// Watches the request and response channels and is bound to the top level.
// ============================================================================
`default_nettype none

module tcpq_checker
   import tcpq_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [CMD_W-1:0]    req_cmd,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [WORD_W-1:0]   rsp_out_id_low,
   input wire logic [TAIL_W-1:0]   rsp_out_id_high,
   input wire logic [WORD_W-1:0]   rsp_out_label_w0,
   input wire logic [WORD_W-1:0]   rsp_out_label_w1,
   input wire logic [WORD_W-1:0]   rsp_out_label_w2,
   input wire logic [TAIL_W-1:0]   rsp_out_label_w3
);

   logic req_fire;
   logic not_served;
   logic no_chars;

   assign req_fire   = req_valid && req_ready;
   assign not_served = (rsp_status != STATUS_SERVED_URG) && (rsp_status != STATUS_SERVED_REG);
   assign no_chars   = (rsp_out_id_low == '0) && (rsp_out_id_high == '0) &&
                       (rsp_out_label_w0 == '0) && (rsp_out_label_w1 == '0) &&
                       (rsp_out_label_w2 == '0) && (rsp_out_label_w3 == '0);

   // A waiting response word holds its status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response word changed while stalled");

   // Every accepted request produces a response word in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted request gave no response");

   // An append answers queued or dropped.
   a_append_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_APPEND_REGULAR || req_cmd == CMD_APPEND_EMERGENCY)
      |=> rsp_status == STATUS_QUEUED || rsp_status == STATUS_DROPPED)
      else $error("append answered with a service status");

   // A serve answers with an entry or idle.
   a_serve_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == CMD_SERVE
      |=> rsp_status == STATUS_SERVED_URG || rsp_status == STATUS_SERVED_REG ||
          rsp_status == STATUS_IDLE)
      else $error("serve answered with an append status");

   // Characters are only shown for a served entry.
   a_zero_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && not_served |-> no_chars)
      else $error("characters present on a response without service");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_cmd          (req.cmd),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_out_id_low   (rsp.out_id_low),
   .rsp_out_id_high  (rsp.out_id_high),
   .rsp_out_label_w0 (rsp.out_label_w0),
   .rsp_out_label_w1 (rsp.out_label_w1),
   .rsp_out_label_w2 (rsp.out_label_w2),
   .rsp_out_label_w3 (rsp.out_label_w3)
);

`default_nettype wire
